// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the matrix-vector multiply RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CHK_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/mvm_pkg.sv -----
// Types, sizes and codes shared by the matrix-vector multiply modules.
`default_nettype none

package mvm_pkg;

    // Array dimensions.
    localparam int ROWS = 16;
    localparam int COLS = 16;

    // Index and count widths derived from the dimensions.
    localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_IDX_W = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int ROW_CNT_W = $clog2(ROWS + 1);
    localparam int COL_CNT_W = $clog2(COLS + 1);

    // Fixed field widths.
    localparam int KIND_W      = 2;
    localparam int ROW_FIELD_W = 4;
    localparam int COL_FIELD_W = 4;
    localparam int VAL_W       = 16;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int SUM_W       = 36;
    localparam int DIM_W       = 5;

    // Command kinds.
    localparam logic [KIND_W-1:0] KIND_VEC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MAT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CMP = 2'd2;

    // Register select (address bit 2).
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // One command beat.
    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [ROW_FIELD_W-1:0]  row;
        logic [COL_FIELD_W-1:0]  col;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    // One result beat.
    typedef struct packed {
        logic [ROW_FIELD_W-1:0]  out_row;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } result_t;

    // Vector element travelling along the cell chain.
    typedef struct packed {
        logic                    valid;
        logic                    first;
        logic                    last;
        logic                    kill;
        logic [COL_IDX_W-1:0]    col;
        logic signed [VAL_W-1:0] val;
    } link_t;

    // Status of the cell selected for output.
    typedef struct packed {
        logic                    done;
        logic signed [SUM_W-1:0] sum;
    } chain_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/mvm_cell.sv -----
// One chain cell: holds a matrix row and accumulates its dot product.
`default_nettype none
`include "assert_macros.svh"

module mvm_cell
    import mvm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire link_t                   link_in,
    input  wire logic                    wr_en,
    input  wire logic [COL_IDX_W-1:0]    wr_col,
    input  wire logic signed [VAL_W-1:0] wr_val,
    output link_t                        link_out,
    output logic signed [SUM_W-1:0]      acc,
    output logic                         done
);

    logic signed [VAL_W-1:0]  row_mem [COLS];
    link_t                    link_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic                     prod_first_reg;
    logic                     prod_last_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  acc_next;
    logic                     done_reg;

    // Row storage, written by matrix load beats addressed to this row.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_col] <= wr_val;
        end
    end

    // Stage register that hands the vector element on to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_in;
        end
    end

    assign link_out = link_reg;

    // Product of the passing vector element and this row's entry.
    always_ff @(posedge clk)
    begin
        if (link_reg.kill)
        begin
            prod_reg <= '0;
        end
        else
        begin
            prod_reg <= link_reg.val * row_mem[link_reg.col];
        end
        prod_first_reg <= link_reg.first;
        prod_last_reg  <= link_reg.last;
    end

    // Accumulation restarts on the first column of each compute.
    always_comb
    begin
        if (prod_first_reg)
        begin
            acc_next = SUM_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg + SUM_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_valid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // Valid and done flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= link_reg.valid;
            done_reg       <= link_reg.valid ? 1'b0 : (prod_valid_reg && prod_last_reg);
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

    // A compute finishes a row once, so done is a single-cycle pulse.
    `CHK_NEXT(a_done_pulse, done_reg, !done_reg, "cell done held for two cycles")

endmodule

`default_nettype wire

// ----- rtl/core/mvm_ctrl.sv -----
// Sequencer: vector store, feed into the cell chain and result output.
`default_nettype none
`include "assert_macros.svh"

module mvm_ctrl
    import mvm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire cmd_t                 cmd,
    input  wire logic [DIM_W-1:0]     rows_used,
    input  wire logic [DIM_W-1:0]     cols_used,
    input  wire chain_stat_t          stat,
    output logic                      busy,
    output link_t                     feed,
    output logic [ROW_IDX_W-1:0]      emit_idx,
    output logic                      result_valid,
    output result_t                   result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FEED = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic signed [VAL_W-1:0] vec_mem [COLS];

    logic [1:0]            state_reg, state_next;
    logic                  busy_reg, busy_next;
    logic [COL_CNT_W-1:0]  col_cnt_reg, col_cnt_next;
    logic [ROW_IDX_W-1:0]  emit_cnt_reg, emit_cnt_next;
    logic                  feed_valid_reg, feed_valid_next;
    logic                  feed_first_reg, feed_last_reg, feed_kill_reg;
    logic [COL_IDX_W-1:0]  feed_col_reg;
    logic signed [VAL_W-1:0] feed_val_reg;
    logic                  result_valid_reg, result_valid_next;
    result_t               result_reg;

    logic                  accept;
    logic                  vec_we;
    logic [ROW_CNT_W-1:0]  nr;
    logic [COL_CNT_W-1:0]  nc;
    logic                  nc_zero;
    logic                  feed_last;
    logic                  emit;
    logic                  emit_last;
    logic [COL_IDX_W-1:0]  col_idx;

    assign accept = start && !busy_reg;
    assign vec_we = accept && (cmd.kind == KIND_VEC) && (32'(cmd.col) < COLS);

    // Dimensions in use, saturated to the array size.
    assign nr = (32'(rows_used) > ROWS) ? ROW_CNT_W'(ROWS) : ROW_CNT_W'(rows_used);
    assign nc = (32'(cols_used) > COLS) ? COL_CNT_W'(COLS) : COL_CNT_W'(cols_used);
    assign nc_zero   = (nc == '0);
    assign feed_last = nc_zero || ((col_cnt_reg + COL_CNT_W'(1)) == nc);
    assign emit_last = ((ROW_CNT_W'(emit_cnt_reg) + ROW_CNT_W'(1)) == nr);
    assign col_idx   = COL_IDX_W'(col_cnt_reg);

    // Next-state logic.
    always_comb
    begin
        state_next        = state_reg;
        busy_next         = busy_reg;
        col_cnt_next      = col_cnt_reg;
        emit_cnt_next     = emit_cnt_reg;
        feed_valid_next   = 1'b0;
        emit              = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.kind == KIND_CMP) && (nr != '0))
                begin
                    state_next   = S_FEED;
                    busy_next    = 1'b1;
                    col_cnt_next = '0;
                end
            end
            S_FEED:
            begin
                feed_valid_next = 1'b1;
                if (feed_last)
                begin
                    state_next    = S_WAIT;
                    emit_cnt_next = '0;
                end
                else
                begin
                    col_cnt_next = col_cnt_reg + COL_CNT_W'(1);
                end
            end
            S_WAIT, S_EMIT:
            begin
                if (stat.done)
                begin
                    emit = 1'b1;
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                        busy_next  = 1'b0;
                    end
                    else
                    begin
                        state_next    = S_EMIT;
                        emit_cnt_next = emit_cnt_reg + ROW_IDX_W'(1);
                    end
                end
            end
        endcase
        result_valid_next = emit;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            busy_reg         <= 1'b0;
            col_cnt_reg      <= '0;
            emit_cnt_reg     <= '0;
            feed_valid_reg   <= 1'b0;
            feed_first_reg   <= 1'b0;
            feed_last_reg    <= 1'b0;
            feed_kill_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            busy_reg         <= busy_next;
            col_cnt_reg      <= col_cnt_next;
            emit_cnt_reg     <= emit_cnt_next;
            feed_valid_reg   <= feed_valid_next;
            feed_first_reg   <= feed_valid_next && (col_cnt_reg == '0);
            feed_last_reg    <= feed_valid_next && feed_last;
            feed_kill_reg    <= feed_valid_next && nc_zero;
            result_valid_reg <= result_valid_next;
        end
    end

    // Vector store write and registered read for the feed beat.
    always_ff @(posedge clk)
    begin
        if (vec_we)
        begin
            vec_mem[COL_IDX_W'(cmd.col)] <= cmd.value;
        end
        feed_col_reg <= col_idx;
        feed_val_reg <= vec_mem[col_idx];
    end

    // Result register, loaded as each row's sum is taken from the chain.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg.out_row <= ROW_FIELD_W'(emit_cnt_reg);
            result_reg.sum     <= stat.sum;
            result_reg.last    <= emit_last;
        end
    end

    always_comb
    begin
        feed.valid = feed_valid_reg;
        feed.first = feed_first_reg;
        feed.last  = feed_last_reg;
        feed.kill  = feed_kill_reg;
        feed.col   = feed_col_reg;
        feed.val   = feed_val_reg;
    end

    assign busy         = busy_reg;
    assign emit_idx     = emit_cnt_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Each row finishes in the cycle after the row before it, so every emitting cycle finds its row done.
    `CHK_IMPLY(a_emit_done, state_reg == S_EMIT, stat.done, "row not ready during output")
    // A row only reports done while results are awaited.
    `CHK_IMPLY(a_done_when_waiting, stat.done, (state_reg == S_WAIT) || (state_reg == S_EMIT), "row done outside a compute")
    // The final result beat leaves the block idle.
    `CHK_IMPLY(a_last_idle, result_valid_reg && result_reg.last, (state_reg == S_IDLE) && !busy_reg, "busy after final result")

endmodule

`default_nettype wire

// ----- rtl/core/matrix_vector_multiply.sv -----
// Top level of the matrix-vector multiply: register port, cell chain and sequencer.
//
// Usage. Commands enter on cmd when start is high and busy is low, one beat
// per cycle. A vector load (kind 0) or matrix load (kind 1) writes one Q8.8
// entry and leaves busy low, so loads stream at one per cycle. A compute
// beat (kind 2) raises busy from the next cycle: the vector is fed down a
// chain of one cell per matrix row, one column per cycle, each cell adding
// its products in the cycle after its neighbour. The column count in use is
// cols_used clamped to 1..16 and the row count is rows_used clamped to 16.
// Results come on result in row order, one per cycle, last set on the final
// row. busy falls as the final beat appears, and the next command can be
// taken from then on; the column feed and the chain length set when this
// happens. Each result is shown on result for one cycle under result_valid;
// the receiver cannot stall. A compute with rows_used of zero emits nothing
// and leaves busy low. rows_used and cols_used are written over the APB port
// (addresses 0 and 4); the user must write them only while busy is low, as
// the block itself does not enforce this. Reset clears the control state and
// sets both registers to 16; the stores need no clearing.
`default_nettype none

module matrix_vector_multiply
    import mvm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire cmd_t        cmd,
    output logic             busy,
    output logic             result_valid,
    output result_t          result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [DIM_W-1:0]        rows_used_reg;
    logic [DIM_W-1:0]        cols_used_reg;
    logic                    cfg_we;
    logic                    mat_we;
    link_t                   feed;
    link_t                   links [ROWS];
    logic [ROWS-1:0]         done_vec;
    logic signed [SUM_W-1:0] sum_arr [ROWS];
    logic [ROW_IDX_W-1:0]    emit_idx;
    chain_stat_t             stat;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg <= DIM_W'(16);
            cols_used_reg <= DIM_W'(16);
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_ROWS)
            begin
                rows_used_reg <= pwdata[DIM_W-1:0];
            end
            else
            begin
                cols_used_reg <= pwdata[DIM_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_COLS) ? 32'(cols_used_reg) : 32'(rows_used_reg);

    // Matrix load beats go to the cell that holds the addressed row.
    assign mat_we = start && !busy && (cmd.kind == KIND_MAT)
                    && (32'(cmd.row) < ROWS) && (32'(cmd.col) < COLS);

    // Chain of row cells; each passes the vector element to its neighbour.
    for (genvar r = 0; r < ROWS; r++)
    begin : g_cell
        mvm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .link_in  ((r == 0) ? feed : links[(r == 0) ? 0 : r - 1]),
            .wr_en    (mat_we && (32'(cmd.row) == r)),
            .wr_col   (COL_IDX_W'(cmd.col)),
            .wr_val   (cmd.value),
            .link_out (links[r]),
            .acc      (sum_arr[r]),
            .done     (done_vec[r])
        );
    end

    // Select the row currently being output.
    always_comb
    begin
        stat.done = done_vec[emit_idx];
        stat.sum  = sum_arr[emit_idx];
    end

    mvm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .rows_used    (rows_used_reg),
        .cols_used    (cols_used_reg),
        .stat         (stat),
        .busy         (busy),
        .feed         (feed),
        .emit_idx     (emit_idx),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
